// ===== rtl/vm_instruction_executor_core_defines.svh =====
// Assertion macros shared by the executor RTL
`ifndef VM_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define VM_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define VMX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define VMX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/vmx_pkg.sv =====
// Types and constants for the instruction executor
`timescale 1ns / 1ps
package vmx_pkg;
  localparam logic [11:0] PcStartRst  = 12'd512;
  localparam logic [11:0] FontBaseRst = 12'd80;
  localparam logic [15:0] OpRet       = 16'h00EE;
  localparam logic [7:0]  KkKeyDown   = 8'h9E;
  localparam logic [7:0]  KkKeyUp     = 8'hA1;
  localparam logic [7:0]  KkGetDelay  = 8'h07;
  localparam logic [7:0]  KkSetDelay  = 8'h15;
  localparam logic [7:0]  KkSetSound  = 8'h18;
  localparam logic [7:0]  KkAddIndex  = 8'h1E;
  localparam logic [7:0]  KkFont      = 8'h29;
  localparam logic [7:0]  KkBcd       = 8'h33;
  localparam logic [7:0]  KkStore     = 8'h55;
  localparam logic [0:0]  AddrPcStart  = 1'b0;
  localparam logic [0:0]  AddrFontBase = 1'b1;
  localparam logic [1:0]  FaultNone  = 2'd0;
  localparam logic [1:0]  FaultOver  = 2'd1;
  localparam logic [1:0]  FaultUnder = 2'd2;

  // ALU operations of the shared unit
  typedef enum logic [3:0] {
    AluPass = 4'd0, AluOr = 4'd1, AluAnd = 4'd2, AluXor = 4'd3, AluAdd = 4'd4,
    AluSub = 4'd5, AluShr = 4'd6, AluSubn = 4'd7, AluShl = 4'd8
  } alu_op_e;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
  } alu_res_t;
endpackage

// ===== rtl/vmx_alu.sv =====
// Shared 8-bit ALU with flag for the executor
`timescale 1ns / 1ps
module vmx_alu (
  input  vmx_pkg::alu_op_e op_i,
  input  logic [7:0]       a_i,
  input  logic [7:0]       b_i,
  output vmx_pkg::alu_res_t res_o
);
  logic [8:0] sum;
  assign sum = {1'b0, a_i} + {1'b0, b_i};
  // Compute result and flag for the selected op
  always_comb begin
    res_o = '0;
    case (op_i)
      vmx_pkg::AluPass: res_o.res = b_i;
      vmx_pkg::AluOr:   res_o.res = a_i | b_i;
      vmx_pkg::AluAnd:  res_o.res = a_i & b_i;
      vmx_pkg::AluXor:  res_o.res = a_i ^ b_i;
      vmx_pkg::AluAdd:  begin res_o.res = sum[7:0]; res_o.flag = sum[8]; end
      vmx_pkg::AluSub:  begin res_o.res = a_i - b_i; res_o.flag = (a_i >= b_i); end
      vmx_pkg::AluSubn: begin res_o.res = b_i - a_i; res_o.flag = (b_i >= a_i); end
      vmx_pkg::AluShr:  begin res_o.res = {1'b0, b_i[7:1]}; res_o.flag = b_i[0]; end
      vmx_pkg::AluShl:  begin res_o.res = {b_i[6:0], 1'b0}; res_o.flag = b_i[7]; end
      default: res_o = '0;
    endcase
  end
endmodule

// ===== rtl/vm_instruction_executor_core.sv =====
// Top level: instruction executor with sequencer and register file
// Flow: an accepted word is registered and executed in StExec, and its result is
// registered from there for StOut. BCD and Fx55 go through StWrite instead, which
// gives one write a cycle while the receiver takes each result. A new instruction
// is accepted only in StIdle, after the last result of the one before is taken.
// Reset: registers, index, timers, stack pointer clear; PC loads pc_start.
`timescale 1ns / 1ps
`include "vm_instruction_executor_core_defines.svh"
module vm_instruction_executor_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        instruction_valid_i,
  output logic        instruction_ready_o,
  input  logic [15:0] instruction_i,
  input  logic [7:0]  random_byte_i,
  input  logic [15:0] key_mask_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [15:0] next_pc_o,
  output logic [15:0] index_value_o,
  output logic [7:0]  flag_value_o,
  output logic [7:0]  delay_value_o,
  output logic [7:0]  sound_value_o,
  output logic        write_valid_o,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic [1:0]  fault_o,
  output logic        last_o
);
  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int SiW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [3:0] {
    StIdle = 4'b0001, StExec = 4'b0010, StWrite = 4'b0100, StOut = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [11:0] pc_start_q, font_base_q;
  logic [7:0]  regs_q [16];
  logic [15:0] pc_q, idx_q;
  logic [SpW-1:0] sp_q;
  logic [15:0] stack_q [STACK_DEPTH];
  logic [7:0]  dt_q, st_q;
  logic [15:0] op_q, keys_q;
  logic [7:0]  rnd_q;
  logic [3:0]  cnt_q;
  logic [15:0] base_q;
  logic        bcd_q;
  logic [7:0]  bcd_h, bcd_t, bcd_o;

  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_comb begin
    unique case (paddr[2])
      vmx_pkg::AddrPcStart:  prdata = {20'd0, pc_start_q};
      vmx_pkg::AddrFontBase: prdata = {20'd0, font_base_q};
      default:               prdata = '0;
    endcase
  end

  // Decode fields of the held instruction
  logic [3:0] x, y, nn, grp;
  logic [7:0] kk, vx, vy;
  logic [11:0] nnn;
  assign grp = op_q[15:12];
  assign x = op_q[11:8];
  assign y = op_q[7:4];
  assign nn = op_q[3:0];
  assign kk = op_q[7:0];
  assign nnn = op_q[11:0];
  assign vx = regs_q[x];
  assign vy = regs_q[y];

  vmx_pkg::alu_op_e alu_op;
  vmx_pkg::alu_res_t alu_res;
  logic        alu_valid;
  always_comb begin
    alu_op = vmx_pkg::AluPass;
    alu_valid = 1'b1;
    case (nn)
      4'h0: alu_op = vmx_pkg::AluPass;
      4'h1: alu_op = vmx_pkg::AluOr;
      4'h2: alu_op = vmx_pkg::AluAnd;
      4'h3: alu_op = vmx_pkg::AluXor;
      4'h4: alu_op = vmx_pkg::AluAdd;
      4'h5: alu_op = vmx_pkg::AluSub;
      4'h6: alu_op = vmx_pkg::AluShr;
      4'h7: alu_op = vmx_pkg::AluSubn;
      4'hE: alu_op = vmx_pkg::AluShl;
      default: alu_valid = 1'b0;
    endcase
  end
  vmx_alu u_alu (.op_i(alu_op), .a_i(vx), .b_i(vy), .res_o(alu_res));

  // BCD digits of Vx by compare and subtract
  always_comb begin
    logic [7:0] r;
    r = vx;
    bcd_h = 8'd0;
    if (r >= 8'd200) begin bcd_h = 8'd2; r = r - 8'd200; end
    else if (r >= 8'd100) begin bcd_h = 8'd1; r = r - 8'd100; end
    bcd_t = 8'd0;
    for (int i = 9; i >= 1; i--) begin
      if (bcd_t == 8'd0 && r >= 8'(i * 10)) bcd_t = 8'(i);
    end
    bcd_o = r - 8'(bcd_t * 8'd10);
  end

  logic [15:0] pc2;
  logic        skip, key_dn;
  assign pc2 = pc_q + 16'd2;
  assign key_dn = keys_q[vx[3:0]];
  always_comb begin
    skip = 1'b0;
    case (grp)
      4'h3: skip = (vx == kk);
      4'h4: skip = (vx != kk);
      4'h5: skip = (nn == 4'h0) && (vx == vy);
      4'h9: skip = (nn == 4'h0) && (vx != vy);
      4'hE: skip = (vx < 8'd16) && (((kk == vmx_pkg::KkKeyDown) && key_dn) ||
                                    ((kk == vmx_pkg::KkKeyUp) && !key_dn));
      default: skip = 1'b0;
    endcase
  end

  logic out_fire;
  assign out_fire = result_valid_o & result_ready_i;
  assign instruction_ready_o = (state_q == StIdle);

  always_comb begin
    unique case (state_q)
      StIdle:  state_d = instruction_valid_i ? StExec : StIdle;
      StExec:  state_d = ((grp == 4'hF) && ((kk == vmx_pkg::KkBcd) ||
                          (kk == vmx_pkg::KkStore))) ? StWrite : StOut;
      StWrite: state_d = (out_fire && last_o) ? StIdle : StWrite;
      StOut:   state_d = out_fire ? StIdle : StOut;
      default: state_d = StIdle;
    endcase
  end

  // Execute the held instruction and step writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_start_q <= vmx_pkg::PcStartRst;
      font_base_q <= vmx_pkg::FontBaseRst;
      pc_q <= {4'd0, vmx_pkg::PcStartRst};
      idx_q <= '0;
      sp_q <= '0;
      dt_q <= '0;
      st_q <= '0;
      for (int i = 0; i < 16; i++) regs_q[i] <= '0;
      result_valid_o <= 1'b0;
      fault_o <= vmx_pkg::FaultNone;
      cnt_q <= '0;
      base_q <= '0;
      bcd_q <= 1'b0;
      last_o <= 1'b0;
      write_valid_o <= 1'b0;
      write_address_o <= '0;
      write_data_o <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == vmx_pkg::AddrPcStart) begin
          pc_start_q <= pwdata[11:0];
          pc_q <= {4'd0, pwdata[11:0]};
        end else begin
          font_base_q <= pwdata[11:0];
        end
      end
      unique case (state_q)
        StIdle: ;
        StExec: begin
          fault_o <= vmx_pkg::FaultNone;
          pc_q <= skip ? pc_q + 16'd4 : pc2;
          write_valid_o <= 1'b0;
          write_address_o <= '0;
          write_data_o <= '0;
          last_o <= 1'b1;
          result_valid_o <= 1'b1;
          cnt_q <= '0;
          base_q <= idx_q;
          bcd_q <= (kk == vmx_pkg::KkBcd);
          case (grp)
            4'h0: if (op_q == vmx_pkg::OpRet) begin
              if (sp_q == '0) fault_o <= vmx_pkg::FaultUnder;
              else begin
                sp_q <= sp_q - 1'b1;
                pc_q <= stack_q[SiW'(sp_q - 1'b1)];
              end
            end
            4'h1: pc_q <= {4'd0, nnn};
            4'h2: if (sp_q >= SpW'(STACK_DEPTH)) fault_o <= vmx_pkg::FaultOver;
              else begin
                sp_q <= sp_q + 1'b1;
                pc_q <= {4'd0, nnn};
              end
            4'h6: regs_q[x] <= kk;
            4'h7: regs_q[x] <= vx + kk;
            4'h8: if (alu_valid) begin
              regs_q[x] <= alu_res.res;
              if (nn >= 4'h1 && nn <= 4'h3) regs_q[15] <= 8'd0;
              else if (nn != 4'h0) regs_q[15] <= {7'd0, alu_res.flag};
            end
            4'hA: idx_q <= {4'd0, nnn};
            4'hB: pc_q <= {4'd0, nnn} + {8'd0, regs_q[0]};
            4'hC: regs_q[x] <= rnd_q & kk;
            4'hF: case (kk)
              vmx_pkg::KkGetDelay: regs_q[x] <= dt_q;
              vmx_pkg::KkSetDelay: dt_q <= vx;
              vmx_pkg::KkSetSound: st_q <= vx;
              vmx_pkg::KkAddIndex: idx_q <= idx_q + {8'd0, vx};
              vmx_pkg::KkFont: idx_q <= {4'd0, font_base_q} + {6'd0, vx, 2'd0} +
                                        {8'd0, vx};
              vmx_pkg::KkBcd: begin
                result_valid_o <= 1'b0;
              end
              vmx_pkg::KkStore: begin
                result_valid_o <= 1'b0;
                idx_q <= idx_q + {12'd0, x} + 16'd1;
              end
              default: ;
            endcase
            default: ;
          endcase
        end
        StWrite: begin
          if (!result_valid_o || out_fire) begin
            if (result_valid_o && last_o) begin
              result_valid_o <= 1'b0;
            end else begin
              result_valid_o <= 1'b1;
              write_valid_o <= 1'b1;
              write_address_o <= base_q + {12'd0, cnt_q};
              if (bcd_q) begin
                write_data_o <= (cnt_q == 4'd0) ? bcd_h : (cnt_q == 4'd1) ? bcd_t : bcd_o;
                last_o <= (cnt_q == 4'd2);
              end else begin
                write_data_o <= regs_q[cnt_q];
                last_o <= (cnt_q == x);
              end
              cnt_q <= cnt_q + 4'd1;
            end
          end
        end
        StOut: if (out_fire) result_valid_o <= 1'b0;
        default: ;
      endcase
    end
  end

  // Capture the input word and write the return stack
  always_ff @(posedge clk_i) begin
    if (instruction_valid_i && instruction_ready_o) begin
      op_q <= instruction_i;
      rnd_q <= random_byte_i;
      keys_q <= key_mask_i;
    end
    if (state_q == StExec && grp == 4'h2 && sp_q < SpW'(STACK_DEPTH))
      stack_q[SiW'(sp_q)] <= pc2;
  end

  assign next_pc_o = pc_q;
  assign index_value_o = idx_q;
  assign flag_value_o = regs_q[15];
  assign delay_value_o = dt_q;
  assign sound_value_o = st_q;

  `VMX_ASSERT_IMP(a_sp_range, clk_i, rst_ni, 1'b1, sp_q <= SpW'(STACK_DEPTH), "sp overflow")
  `VMX_ASSERT_IMP(a_no_ready_busy, clk_i, rst_ni, result_valid_o, !instruction_ready_o, "ready while result pending")
  `VMX_ASSERT_IMP(a_fault_single, clk_i, rst_ni, result_valid_o && fault_o != vmx_pkg::FaultNone, last_o && !write_valid_o, "fault on write")
  `VMX_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, instruction_valid_i && instruction_ready_o, state_q == StExec, "accept not executed")
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the instruction executor: directed and random words, checked against a predictor
`timescale 1ns / 1ps
module tb_top;

  localparam int StackDepth = 16;
  localparam int WatchLimit = 4000;

  typedef struct {
    logic [15:0] next_pc;
    logic [15:0] index_value;
    logic [7:0]  flag_value;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  fault;
    logic        last;
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:2]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        instruction_valid_i = 1'b0;
  logic        instruction_ready_o;
  logic [15:0] instruction_i = '0;
  logic [7:0]  random_byte_i = '0;
  logic [15:0] key_mask_i = '0;
  logic        result_valid_o;
  logic        result_ready_i = 1'b0;
  logic [15:0] next_pc_o, index_value_o, write_address_o;
  logic [7:0]  flag_value_o, delay_value_o, sound_value_o, write_data_o;
  logic        write_valid_o, last_o;
  logic [1:0]  fault_o;

  // Predictor state
  logic [7:0]  vreg [16];
  logic [15:0] ret_stack [StackDepth];
  logic [15:0] pc_m, index_m;
  logic [5:0]  sp_m;
  logic [7:0]  delay_m, sound_m;
  logic [11:0] font_m;

  exec_result_t pending_q[$];
  int unsigned  mismatches = 0;
  int unsigned  stall_left = 0;
  bit           idle_on = 1'b1;
  int unsigned  quiet_cycles = 0;

  vm_instruction_executor_core #(.STACK_DEPTH(StackDepth)) i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .instruction_valid_i, .instruction_ready_o, .instruction_i, .random_byte_i,
    .key_mask_i, .result_valid_o, .result_ready_i, .next_pc_o, .index_value_o,
    .flag_value_o, .delay_value_o, .sound_value_o, .write_valid_o,
    .write_address_o, .write_data_o, .fault_o, .last_o
  );

  always #10 clk_i = ~clk_i;

  // Queue one expected result built from the current predictor state
  task automatic push_result(logic wv, logic [15:0] addr, logic [7:0] data,
                             logic [1:0] flt, logic lst);
    exec_result_t r;
    r.next_pc = pc_m;
    r.index_value = index_m;
    r.flag_value = vreg[15];
    r.delay_value = delay_m;
    r.sound_value = sound_m;
    r.write_valid = wv;
    r.write_address = wv ? addr : 16'h0;
    r.write_data = wv ? data : 8'h0;
    r.fault = flt;
    r.last = lst;
    pending_q.push_back(r);
  endtask

  // Execute one word on the predictor and queue what it produces
  task automatic execute_word(logic [15:0] op, logic [7:0] rnd, logic [15:0] keys);
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn;
    logic [8:0]  sum;
    logic [15:0] base;
    logic [1:0]  flt;
    logic        down;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
    flt = vmx_pkg::FaultNone;
    pc_m = pc_m + 16'd2;
    vx = vreg[x]; vy = vreg[y];
    case (op[15:12])
      4'h0: begin
        if (op == vmx_pkg::OpRet) begin
          if (sp_m == 0) flt = vmx_pkg::FaultUnder;
          else begin
            sp_m = sp_m - 1;
            pc_m = ret_stack[sp_m];
          end
        end
      end
      4'h1: pc_m = {4'h0, nnn};
      4'h2: begin
        if (sp_m >= StackDepth) flt = vmx_pkg::FaultOver;
        else begin
          ret_stack[sp_m] = pc_m;
          sp_m = sp_m + 1;
          pc_m = {4'h0, nnn};
        end
      end
      4'h3: if (vx == kk) pc_m = pc_m + 16'd2;
      4'h4: if (vx != kk) pc_m = pc_m + 16'd2;
      4'h5: if (n == 0 && vx == vy) pc_m = pc_m + 16'd2;
      4'h6: vreg[x] = kk;
      4'h7: vreg[x] = vx + kk;
      4'h8: begin
        case (n)
          4'h0: vreg[x] = vy;
          4'h1: begin vreg[x] = vx | vy; vreg[15] = 8'h0; end
          4'h2: begin vreg[x] = vx & vy; vreg[15] = 8'h0; end
          4'h3: begin vreg[x] = vx ^ vy; vreg[15] = 8'h0; end
          4'h4: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vreg[x] = sum[7:0]; vreg[15] = {7'h0, sum[8]};
          end
          4'h5: begin vreg[x] = vx - vy; vreg[15] = {7'h0, vx >= vy}; end
          4'h6: begin vreg[x] = vy >> 1; vreg[15] = {7'h0, vy[0]}; end
          4'h7: begin vreg[x] = vy - vx; vreg[15] = {7'h0, vy >= vx}; end
          4'hE: begin vreg[x] = vy << 1; vreg[15] = {7'h0, vy[7]}; end
          default: ;
        endcase
      end
      4'h9: if (n == 0 && vx != vy) pc_m = pc_m + 16'd2;
      4'hA: index_m = {4'h0, nnn};
      4'hB: pc_m = {4'h0, nnn} + {8'h0, vreg[0]};
      4'hC: vreg[x] = rnd & kk;
      4'hD: ;
      4'hE: begin
        if (vx < 16) begin
          down = keys[vx[3:0]];
          if ((kk == vmx_pkg::KkKeyDown && down) || (kk == vmx_pkg::KkKeyUp && !down))
            pc_m = pc_m + 16'd2;
        end
      end
      default: begin
        case (kk)
          vmx_pkg::KkGetDelay: vreg[x] = delay_m;
          vmx_pkg::KkSetDelay: delay_m = vx;
          vmx_pkg::KkSetSound: sound_m = vx;
          vmx_pkg::KkAddIndex: index_m = index_m + {8'h0, vx};
          vmx_pkg::KkFont:     index_m = {4'h0, font_m} + 16'(vx) * 16'd5;
          vmx_pkg::KkBcd: begin
            base = index_m;
            push_result(1'b1, base, vx / 100, vmx_pkg::FaultNone, 1'b0);
            push_result(1'b1, base + 16'd1, (vx / 10) % 10, vmx_pkg::FaultNone, 1'b0);
            push_result(1'b1, base + 16'd2, vx % 10, vmx_pkg::FaultNone, 1'b1);
            return;
          end
          vmx_pkg::KkStore: begin
            base = index_m;
            index_m = index_m + 16'(x) + 16'd1;
            for (int i = 0; i <= x; i++)
              push_result(1'b1, base + 16'(i), vreg[i], vmx_pkg::FaultNone, i == x);
            return;
          end
          default: ;
        endcase
      end
    endcase
    push_result(1'b0, 16'h0, 8'h0, flt, 1'b1);
  endtask

  // Send one word, with an optional leading gap; return at the accepting edge
  task automatic send_word(logic [15:0] op, logic [7:0] rnd = 8'h00,
                           logic [15:0] keys = 16'h0000);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      instruction_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    instruction_i <= op;
    random_byte_i <= rnd;
    key_mask_i <= keys;
    instruction_valid_i <= 1'b1;
    do @(posedge clk_i); while (!instruction_ready_o);
    execute_word(op, rnd, keys);
  endtask

  // Drop valid and wait for every expected result, then let the block settle
  task automatic drain;
    instruction_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Register write over the APB port while the block is idle
  task automatic write_reg(logic addr_sel, logic [11:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= addr_sel; pwdata <= {20'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr_sel == vmx_pkg::AddrPcStart) pc_m = {4'h0, value};
    else font_m = value;
    @(posedge clk_i);
  endtask

  // Random word, biased toward meaningful encodings
  function automatic logic [15:0] pick_word();
    logic [3:0] grp, x, y;
    logic [7:0] kk;
    logic [7:0] fx_codes [9] = '{vmx_pkg::KkGetDelay, vmx_pkg::KkSetDelay,
                                 vmx_pkg::KkSetSound, vmx_pkg::KkAddIndex,
                                 vmx_pkg::KkFont, vmx_pkg::KkBcd, vmx_pkg::KkStore,
                                 8'h0A, 8'h65};
    logic [3:0] alu_codes [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6,
                                   4'h7, 4'hE, 4'h8};
    grp = $urandom_range(0, 15);
    x = $urandom_range(0, 15);
    y = $urandom_range(0, 15);
    kk = $urandom_range(0, 255);
    if ($urandom_range(0, 15) == 0) return 16'($urandom_range(0, 65535));
    case (grp)
      4'h0: return ($urandom_range(0, 1) != 0) ? vmx_pkg::OpRet
                                               : 16'($urandom_range(0, 4095));
      4'h6: return {grp, x, ($urandom_range(0, 1) != 0) ? {4'h0, y} : kk};
      4'h8: return {grp, x, y, alu_codes[$urandom_range(0, 9)]};
      4'hE: return {grp, x, ($urandom_range(0, 1) != 0) ? vmx_pkg::KkKeyDown
                                                        : vmx_pkg::KkKeyUp};
      4'hF: return {grp, x, fx_codes[$urandom_range(0, 8)]};
      default: return {grp, x, y, 4'($urandom_range(0, 15))};
    endcase
  endfunction

  task automatic test_alu;
    send_word(16'h60FF); send_word(16'h6101); send_word(16'h8014);
    send_word(16'h6080); send_word(16'h8F06); send_word(16'h8F0E);
    send_word(16'h8015); send_word(16'h8017); send_word(16'h8011);
    send_word(16'h8012); send_word(16'h8013); send_word(16'h8018);
    send_word(16'h7FFF); send_word(16'hC0FF, 8'hA5);
  endtask

  task automatic test_flow;
    send_word(16'h00EE); send_word(16'h00E0); send_word(16'hD123);
    send_word(16'h3000); send_word(16'h4000); send_word(16'h5010); send_word(16'h5011);
    send_word(16'h9010); send_word(16'h1FFF); send_word(16'hBFFF); send_word(16'h6220);
    send_word(16'hE29E, 8'h00, 16'hFFFF); send_word(16'hE2A1, 8'h00, 16'h0000);
    send_word(16'h6205);
    send_word(16'hE29E, 8'h00, 16'h0020); send_word(16'hE2A1, 8'h00, 16'h0000);
  endtask

  task automatic test_misc;
    send_word(16'h6FFF); send_word(16'hFF15); send_word(16'hFF18); send_word(16'hF307);
    send_word(16'hAFFF); send_word(16'hFF1E); send_word(16'hFF29); send_word(16'hFF33);
    send_word(16'hFF55); send_word(16'hF055); send_word(16'hF00A); send_word(16'hF065);
  endtask

  // Fill the return stack past its depth, then unwind past empty
  task automatic test_stack;
    for (int i = 0; i <= StackDepth; i++) send_word({4'h2, 12'($urandom_range(0, 4095))});
    for (int i = 0; i <= StackDepth; i++) send_word(vmx_pkg::OpRet);
  endtask

  task automatic test_config;
    write_reg(vmx_pkg::AddrPcStart, 12'hFFF);
    write_reg(vmx_pkg::AddrFontBase, 12'hFFF);
    send_word(16'h60FF); send_word(16'hF029); send_word(16'h3000);
    write_reg(vmx_pkg::AddrPcStart, 12'h000);
    write_reg(vmx_pkg::AddrFontBase, 12'h000);
    send_word(16'hF029); send_word(16'h00E0);
    write_reg(vmx_pkg::AddrFontBase, 12'($urandom_range(0, 4095)));
    write_reg(vmx_pkg::AddrPcStart, 12'($urandom_range(0, 4095)));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      if (i == count * 3 / 4) idle_on = 1'b0;
      send_word(pick_word(), 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    end
  endtask

  // Receiver: ready with random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 10);
      result_ready_i <= 1'b0;
    end else begin
      result_ready_i <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    exec_result_t e;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, pc %h", next_pc_o);
      end else begin
        e = pending_q.pop_front();
        if (next_pc_o !== e.next_pc || index_value_o !== e.index_value ||
            flag_value_o !== e.flag_value || delay_value_o !== e.delay_value ||
            sound_value_o !== e.sound_value || write_valid_o !== e.write_valid ||
            write_address_o !== e.write_address || write_data_o !== e.write_data ||
            fault_o !== e.fault || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp pc %h idx %h vf %h dt %h st %h wv %b wa %h wd %h f %0d l %b",
                     e.next_pc, e.index_value, e.flag_value, e.delay_value, e.sound_value,
                     e.write_valid, e.write_address, e.write_data, e.fault, e.last);
            $display("         got pc %h idx %h vf %h dt %h st %h wv %b wa %h wd %h f %0d l %b",
                     next_pc_o, index_value_o, flag_value_o, delay_value_o, sound_value_o,
                     write_valid_o, write_address_o, write_data_o, fault_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((instruction_valid_i && instruction_ready_o) || (result_valid_o && result_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("vm_instruction_executor_core test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) vreg[i] = 8'h0;
    for (int i = 0; i < StackDepth; i++) ret_stack[i] = 16'h0;
    pc_m = {4'h0, vmx_pkg::PcStartRst}; font_m = vmx_pkg::FontBaseRst;
    index_m = 16'h0; sp_m = '0; delay_m = 8'h0; sound_m = 8'h0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_alu();
    test_flow();
    test_misc();
    test_stack();
    test_config();
    test_random(240);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("vm_instruction_executor_core test passed");
    end else begin
      $display("vm_instruction_executor_core test failed");
    end
    $finish;
  end
endmodule

// ===== vm_instruction_executor_core.f =====
+incdir+rtl
rtl/vmx_pkg.sv
rtl/vmx_alu.sv
rtl/vm_instruction_executor_core.sv
tb/tb_top.sv
